FILE: sv/tsi_pkg.sv
// Shared types, constants and lookup functions for the terrain shade index unit.
// Depends on nothing; every other file but tsi_ram imports it.
`default_nettype none
package tsi_pkg;

	// Map geometry: power-of-two sides so that wrapping is a bit-select
	localparam int MAP_W_BITS = 7;
	localparam int MAP_H_BITS = 7;
	localparam int MAP_W      = 1 << MAP_W_BITS;
	localparam int MAP_H      = 1 << MAP_H_BITS;
	localparam int ADDR_BITS  = MAP_W_BITS + MAP_H_BITS;
	localparam int MAP_DEPTH  = MAP_W * MAP_H;
	localparam int H_BITS     = 16;

	// Coordinate arithmetic, signed, wide enough for three cells past either edge
	localparam int C_BITS = 10;

	// Fade table
	localparam int FADE_ROWS = 256;
	localparam int FADE_SIZE = 65536;
	localparam int IDX_BITS  = 17;

	// Shading constants
	localparam int ROW_OFFSET   = 140;
	localparam int U_BASE       = 64;
	localparam int CLIFF_DARK   = 16;
	localparam int FILT_THRESH  = 10;
	localparam int SHADOW_MAX   = 16;
	localparam int SHADOW_SHIFT = 13;
	localparam int SHADOW_LIM   = SHADOW_MAX << SHADOW_SHIFT;

	// Sequencer sizes
	localparam int NUM_PTS   = 13;
	localparam int NUM_TAPS  = 9;
	localparam int SUM_BITS  = 20;
	localparam int WSUM_BITS = 5;
	localparam int DIV_STEPS = SUM_BITS;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CLIFF_LIMIT  = 3'd0,
		CFG_LIGHT_DIR_X  = 3'd1,
		CFG_LIGHT_DIR_Y  = 3'd2,
		CFG_SMOOTHING_ON = 3'd3,
		CFG_LIGHTING_ON  = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_SHADE = 1'b1
	} opcode_t;

	typedef struct packed {
		logic              opcode;
		logic [6:0]        col;
		logic [6:0]        row;
		logic [H_BITS-1:0] height_value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] fade_index;
		logic                index_error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAW_RD,
		ST_RAW_WT,
		ST_PT_RD,
		ST_PT_DIV,
		ST_FILT,
		ST_MUL_X,
		ST_MUL_Y,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [SUM_BITS-1:0]  dividend;
		logic [WSUM_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [H_BITS-1:0] quotient;
	} div_rsp_t;

	// Diamond of radius two around the cell: centre, the four filter
	// points, then the outer ring
	function automatic logic signed [2:0] pt_dx(input logic [3:0] p);
		case (p)
			4'd1, 4'd9, 4'd11:  pt_dx = -3'sd1;
			4'd2, 4'd10, 4'd12: pt_dx = 3'sd1;
			4'd5:               pt_dx = -3'sd2;
			4'd6:               pt_dx = 3'sd2;
			default:            pt_dx = 3'sd0;
		endcase
	endfunction

	function automatic logic signed [2:0] pt_dy(input logic [3:0] p);
		case (p)
			4'd3, 4'd9, 4'd10:  pt_dy = -3'sd1;
			4'd4, 4'd11, 4'd12: pt_dy = 3'sd1;
			4'd7:               pt_dy = -3'sd2;
			4'd8:               pt_dy = 3'sd2;
			default:            pt_dy = 3'sd0;
		endcase
	endfunction

	// 3x3 kernel taps in raster order
	function automatic logic signed [2:0] tap_dx(input logic [3:0] k);
		case (k)
			4'd0, 4'd3, 4'd6: tap_dx = -3'sd1;
			4'd2, 4'd5, 4'd8: tap_dx = 3'sd1;
			default:          tap_dx = 3'sd0;
		endcase
	endfunction

	function automatic logic signed [2:0] tap_dy(input logic [3:0] k);
		case (k)
			4'd0, 4'd1, 4'd2: tap_dy = -3'sd1;
			4'd6, 4'd7, 4'd8: tap_dy = 3'sd1;
			default:          tap_dy = 3'sd0;
		endcase
	endfunction

	function automatic logic [2:0] tap_w(input logic [3:0] k);
		case (k)
			4'd0, 4'd2, 4'd6, 4'd8: tap_w = 3'd1;
			4'd1, 4'd3, 4'd5, 4'd7: tap_w = 3'd2;
			4'd4:                   tap_w = 3'd4;
			default:                tap_w = 3'd0;
		endcase
	endfunction

	// Four neighbours of filter point j (0 left, 1 right, 2 up, 3 down)
	function automatic logic [3:0] filt_nbr(input logic [1:0] j, input logic [1:0] n);
		case ({j, n})
			4'b00_00: filt_nbr = 4'd5;
			4'b00_01: filt_nbr = 4'd0;
			4'b00_10: filt_nbr = 4'd9;
			4'b00_11: filt_nbr = 4'd11;
			4'b01_00: filt_nbr = 4'd0;
			4'b01_01: filt_nbr = 4'd6;
			4'b01_10: filt_nbr = 4'd10;
			4'b01_11: filt_nbr = 4'd12;
			4'b10_00: filt_nbr = 4'd9;
			4'b10_01: filt_nbr = 4'd10;
			4'b10_10: filt_nbr = 4'd7;
			4'b10_11: filt_nbr = 4'd0;
			4'b11_00: filt_nbr = 4'd11;
			4'b11_01: filt_nbr = 4'd12;
			4'b11_10: filt_nbr = 4'd0;
			default:  filt_nbr = 4'd8;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: sv/terrain_shade_index_unit.sv
// Top level of the terrain shade index unit: sequencer, datapath and config registers.
// Depends on tsi_pkg, tsi_ram and tsi_div.
//
//  channel | signals                          | transaction
//  --------+----------------------------------+--------------------------------
//  input   | start, busy, cmd                 | start & !busy
//  result  | done, result                     | done (one cycle, no back-pressure)
//  config  | cfg_valid, cfg_ready, cfg_index, | cfg_valid & cfg_ready
//          | cfg_data                         | (cfg_ready is always high)
//
// A height write completes in the accepting cycle; busy stays low.
// A shade with lighting off only reads the cell's own height before the final index;
// with lighting on and no smoothing it makes 13 height reads through the single RAM
// read port, then runs the filter, two multiplies and the final sum.
// With smoothing on each of the 13 points takes 9 reads plus a 20-step pass
// through the shared divider.
// Reset clears sequencer and config state; the height map is not cleared.
`default_nettype none
module terrain_shade_index_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire tsi_pkg::in_item_t                   cmd,
	output logic                                     done,
	output tsi_pkg::out_item_t                       result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tsi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [tsi_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import tsi_pkg::*;

	state_t state_q, state_d;

	// Config registers
	logic [15:0]        cliff_limit_q;
	logic signed [15:0] light_dir_x_q;
	logic signed [15:0] light_dir_y_q;
	logic               smoothing_on_q;
	logic               lighting_on_q;

	// Item and sequencer registers
	logic [MAP_W_BITS-1:0] x_q;
	logic [MAP_H_BITS-1:0] y_q;
	logic [3:0]            p_q;
	logic [3:0]            k_q;
	logic                  pend_q;
	logic [2:0]            pend_w_q;
	logic [SUM_BITS-1:0]   acc_q;
	logic [WSUM_BITS-1:0]  wsum_q;
	logic [1:0]            j_q;
	logic [H_BITS-1:0]     hgt_q;
	logic [H_BITS-1:0]     b_q [NUM_PTS];
	logic [H_BITS-1:0]     f_q [4];
	logic signed [32:0]    prod_q;
	logic signed [34:0]    s_q;
	logic                  done_q;
	out_item_t             result_q;
	out_item_t             result_d;

	// Shared units
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic                  ram_we;
	logic [ADDR_BITS-1:0]  ram_raddr;
	logic [H_BITS-1:0]     ram_rdata;

	logic accept;
	logic taps_done;
	logic last_pt;
	logic [3:0] k_init;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign taps_done = (k_q == 4'(NUM_TAPS)) && !pend_q;
	assign last_pt   = p_q == 4'(NUM_PTS - 1);
	assign k_init    = smoothing_on_q ? 4'd0 : 4'd4;

	tsi_ram #(.WIDTH(H_BITS), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({cmd.row, cmd.col}),
		.wdata (cmd.height_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Tap coordinates of the current point, raw and wrapped
	logic signed [2:0]        pdx, pdy, tdx, tdy;
	logic signed [C_BITS-1:0] qx, qy, nx, ny;
	logic                     tap_in;
	logic [2:0]               tap_wt;
	always_comb begin
		pdx = pt_dx(p_q);
		pdy = pt_dy(p_q);
		tdx = tap_dx(k_q);
		tdy = tap_dy(k_q);
		qx = $signed({3'b000, x_q}) + {{(C_BITS-3){pdx[2]}}, pdx};
		qy = $signed({3'b000, y_q}) + {{(C_BITS-3){pdy[2]}}, pdy};
		nx = qx + {{(C_BITS-3){tdx[2]}}, tdx};
		ny = qy + {{(C_BITS-3){tdy[2]}}, tdy};
		tap_in = (nx >= 0) && (nx < C_BITS'(MAP_W)) && (ny >= 0) && (ny < C_BITS'(MAP_H));
		if (!smoothing_on_q) begin
			tap_wt = 3'd1;
		end else begin
			tap_wt = tap_in ? tap_w(k_q) : 3'd0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.opcode == OP_SHADE) state_d = ST_RAW_RD;
			end
			ST_RAW_RD: state_d = ST_RAW_WT;
			ST_RAW_WT: state_d = lighting_on_q ? ST_PT_RD : ST_FINISH;
			ST_PT_RD: begin
				if (taps_done) begin
					if (smoothing_on_q) state_d = ST_PT_DIV;
					else if (last_pt)   state_d = ST_FILT;
				end
			end
			ST_PT_DIV: begin
				if (div_rsp.done) state_d = last_pt ? ST_FILT : ST_PT_RD;
			end
			ST_FILT: begin
				if (j_q == 2'd3) state_d = ST_MUL_X;
			end
			ST_MUL_X:  state_d = ST_MUL_Y;
			ST_MUL_Y:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy             = state_q != ST_IDLE;
		ram_we           = 1'b0;
		ram_raddr        = {ny[MAP_H_BITS-1:0], nx[MAP_W_BITS-1:0]};
		div_req.start    = 1'b0;
		div_req.dividend = acc_q;
		div_req.divisor  = wsum_q;
		case (state_q)
			ST_IDLE:   ram_we = accept && cmd.opcode == OP_WRITE;
			ST_RAW_RD: ram_raddr = {y_q, x_q};
			ST_PT_RD:  div_req.start = taps_done && smoothing_on_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == ST_FINISH;
			pend_q  <= (state_q == ST_PT_RD) && (k_q < 4'(NUM_TAPS));
		end
	end

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cliff_limit_q  <= '0;
			light_dir_x_q  <= '0;
			light_dir_y_q  <= '0;
			smoothing_on_q <= 1'b0;
			lighting_on_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CLIFF_LIMIT:  cliff_limit_q  <= cfg_data;
				CFG_LIGHT_DIR_X:  light_dir_x_q  <= $signed(cfg_data);
				CFG_LIGHT_DIR_Y:  light_dir_y_q  <= $signed(cfg_data);
				CFG_SMOOTHING_ON: smoothing_on_q <= cfg_data[0];
				CFG_LIGHTING_ON:  lighting_on_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Outlier filter of point j_q
	logic [H_BITS+1:0]        nsum;
	logic [H_BITS-1:0]        navg, fh, fval;
	logic signed [H_BITS:0]   fd;
	always_comb begin
		fh   = b_q[{2'b00, j_q} + 4'd1];
		nsum = {2'b00, b_q[filt_nbr(j_q, 2'd0)]} + {2'b00, b_q[filt_nbr(j_q, 2'd1)]}
		     + {2'b00, b_q[filt_nbr(j_q, 2'd2)]} + {2'b00, b_q[filt_nbr(j_q, 2'd3)]};
		navg = nsum[H_BITS+1:2];
		fd   = $signed({1'b0, fh}) - $signed({1'b0, navg});
		fval = (fd > (H_BITS+1)'(FILT_THRESH) || fd < -(H_BITS+1)'(FILT_THRESH)) ? navg : fh;
	end

	// Slopes from the filtered neighbours (0 left, 1 right, 2 up, 3 down)
	logic signed [H_BITS:0] dx, dy;
	logic signed [32:0]     prod_y;
	assign dx     = $signed({1'b0, f_q[1]}) - $signed({1'b0, f_q[0]});
	assign dy     = $signed({1'b0, f_q[3]}) - $signed({1'b0, f_q[2]});
	assign prod_y = dy * light_dir_y_q;

	// Datapath
	always_ff @(posedge clk) begin
		if (pend_q) begin
			acc_q  <= acc_q + ({4'b0000, ram_rdata} * {17'd0, pend_w_q});
			wsum_q <= wsum_q + {2'b00, pend_w_q};
		end
		case (state_q)
			ST_IDLE: begin
				x_q <= cmd.col;
				y_q <= cmd.row;
			end
			ST_RAW_WT: begin
				hgt_q  <= ram_rdata;
				p_q    <= '0;
				k_q    <= k_init;
				acc_q  <= '0;
				wsum_q <= 5'd1;
			end
			ST_PT_RD: begin
				if (k_q < 4'(NUM_TAPS)) begin
					pend_w_q <= tap_wt;
					k_q      <= smoothing_on_q ? k_q + 4'd1 : 4'(NUM_TAPS);
				end else if (taps_done && !smoothing_on_q) begin
					b_q[p_q] <= acc_q[H_BITS-1:0];
					p_q      <= p_q + 4'd1;
					k_q      <= k_init;
					acc_q    <= '0;
					wsum_q   <= 5'd1;
				end
				j_q <= '0;
			end
			ST_PT_DIV: begin
				if (div_rsp.done) begin
					b_q[p_q] <= div_rsp.quotient;
					p_q      <= p_q + 4'd1;
					k_q      <= k_init;
					acc_q    <= '0;
					wsum_q   <= 5'd1;
				end
				j_q <= '0;
			end
			ST_FILT: begin
				f_q[j_q] <= fval;
				j_q      <= j_q + 2'd1;
			end
			ST_MUL_X: prod_q <= dx * light_dir_x_q;
			ST_MUL_Y: s_q <= 35'(prod_q) + 35'(prod_y);
			ST_FINISH: result_q <= result_d;
			default: begin
			end
		endcase
	end

	// Final index
	logic [H_BITS:0]          vsum;
	logic [8:0]               vrow;
	logic [H_BITS:0]          adx, ady;
	logic                     cliff;
	logic signed [34:0]       s_adj;
	logic signed [5:0]        sh;
	logic [H_BITS+1:0]        fsum;
	logic signed [H_BITS+1:0] ao;
	logic signed [19:0]       u, uv;
	always_comb begin
		vsum  = {1'b0, hgt_q} + (H_BITS+1)'(ROW_OFFSET);
		vrow  = (vsum > (H_BITS+1)'(FADE_ROWS)) ? 9'(FADE_ROWS - 1) : vsum[8:0];
		adx   = dx[H_BITS] ? 17'(-dx) : 17'(dx);
		ady   = dy[H_BITS] ? 17'(-dy) : 17'(dy);
		cliff = (adx > {1'b0, cliff_limit_q}) || (ady > {1'b0, cliff_limit_q});
		s_adj = s_q[34] ? s_q + 35'sd8191 : s_q;
		if (s_q < -35'(SHADOW_LIM))     sh = -6'(SHADOW_MAX);
		else if (s_q > 35'(SHADOW_LIM)) sh = 6'(SHADOW_MAX);
		else                            sh = 6'(s_adj >>> SHADOW_SHIFT);
		fsum = {2'b00, f_q[0]} + {2'b00, f_q[1]} + {2'b00, f_q[2]} + {2'b00, f_q[3]};
		ao   = $signed({2'b00, fsum[H_BITS+1:2]}) - $signed({2'b00, hgt_q});
		u    = 20'(U_BASE);
		if (lighting_on_q) begin
			if (cliff) u = u - 20'(CLIFF_DARK);
			u = u + {{14{sh[5]}}, sh};
			if (ao > 0) u = u - {4'b0000, ao[H_BITS+1:2]};
		end
		uv = u + $signed({3'b000, vrow, 8'b0});
		if (uv < 0) begin
			result_d.fade_index  = '0;
			result_d.index_error = 1'b1;
		end else begin
			result_d.fade_index  = uv[IDX_BITS-1:0];
			result_d.index_error = uv > 20'(FADE_SIZE);
		end
	end

	assign done   = done_q;
	assign result = result_q;
endmodule
`default_nettype wire

FILE: sv/tsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package needed.
`default_nettype none
module tsi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/tsi_div.sv
// Restoring divider, one quotient bit per cycle, for the smoothing weight sum.
// Depends on tsi_pkg.
`default_nettype none
module tsi_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tsi_pkg::div_req_t req,
	output tsi_pkg::div_rsp_t      rsp
);
	import tsi_pkg::*;

	logic                 run_q;
	logic [4:0]           cnt_q;
	logic [SUM_BITS-1:0]  quo_q;
	logic [WSUM_BITS-1:0] rem_q;
	logic [WSUM_BITS-1:0] dvs_q;
	logic                 done_q;
	logic [WSUM_BITS:0]   rem_sh;
	logic                 fits;

	// Trial subtract of the shifted remainder
	always_comb begin
		rem_sh = {rem_q, quo_q[SUM_BITS-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? WSUM_BITS'(rem_sh - {1'b0, dvs_q}) : rem_sh[WSUM_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[H_BITS-1:0];
endmodule
`default_nettype wire

FILE: sv/tsi_checker.sv
// Port-level checks on the terrain shade index unit, bound to the top level.
// Depends on tsi_pkg and terrain_shade_index_unit.
`default_nettype none
module tsi_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire tsi_pkg::in_item_t                 cmd,
	input wire logic                              done,
	input wire tsi_pkg::out_item_t                result,
	input wire logic                              cfg_valid,
	input wire logic                              cfg_ready,
	input wire logic [tsi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input wire logic [tsi_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import tsi_pkg::*;

	// A result only ends a shade that was in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a shade in progress");

	// A height write never makes the unit busy
	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode == OP_WRITE) |=> !busy)
		else $error("height write left the unit busy");

	// A shade occupies the unit
	a_shade_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode == OP_SHADE) |=> busy)
		else $error("shade accepted but unit not busy");

	// Error flag agrees with the index
	a_err_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.index_error) |-> (result.fade_index <= IDX_BITS'(FADE_SIZE)))
		else $error("index beyond table without error flag");

endmodule

bind terrain_shade_index_unit tsi_checker u_tsi_checker (.*);
`default_nettype wire
